@@ hdl/v3a_pkg.sv @@
// v3a_pkg: shared types and constants of the 3-D vector ALU.
// Used by every file under hdl; depends on nothing.
`timescale 1ns / 1ps

package v3a_pkg;

    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int FRACTION_BITS_DEF   = 12;
    localparam int SCALAR_WIDTH        = 32;
    localparam int OP_WIDTH            = 3;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD       = 3'd0,
        OP_SUB       = 3'd1,
        OP_CROSS     = 3'd2,
        OP_DOT       = 3'd3,
        OP_SCALE     = 3'd4,
        OP_LENGTH    = 3'd5,
        OP_NORMALIZE = 3'd6,
        OP_NEGATE    = 3'd7
    } op_t;

endpackage

@@ hdl/v3a_mul_cell.sv @@
// v3a_mul_cell: first pipeline cell; linear ops and six operand-selected products.
// Depends on v3a_pkg.
`timescale 1ns / 1ps

module v3a_mul_cell #(
    parameter int CW = v3a_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  v3a_pkg::op_t           in_op,
    input  logic [2:0][CW-1:0]     in_a,
    input  logic [2:0][CW-1:0]     in_b,
    input  logic [CW-1:0]          in_s,
    output logic                   out_valid,
    input  logic                   out_ready,
    output v3a_pkg::op_t           out_op,
    output logic [2:0][CW-1:0]     out_a,
    output logic [2:0][CW:0]       out_lin,
    output logic [5:0][2*CW-1:0]   out_prod
);
    import v3a_pkg::*;

    logic                 valid_reg;
    op_t                  op_reg;
    logic [2:0][CW-1:0]   a_reg;
    logic [2:0][CW:0]     lin_reg;
    logic [2:0][CW:0]     lin_next;
    logic [5:0][2*CW-1:0] prod_reg;
    logic [5:0][2*CW-1:0] prod_next;
    logic [5:0][CW-1:0]   ml;
    logic [5:0][CW-1:0]   mr;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_op    = op_reg;
    assign out_a     = a_reg;
    assign out_lin   = lin_reg;
    assign out_prod  = prod_reg;

    always_comb
    begin
        lin_next = '0;
        ml       = '0;
        mr       = '0;
        unique case (in_op) inside
            OP_ADD:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    lin_next[k] = {in_a[k][CW-1], in_a[k]} + {in_b[k][CW-1], in_b[k]};
                end
            end
            OP_SUB:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    lin_next[k] = {in_a[k][CW-1], in_a[k]} - {in_b[k][CW-1], in_b[k]};
                end
            end
            OP_NEGATE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    lin_next[k] = (CW+1)'(0) - {in_a[k][CW-1], in_a[k]};
                end
            end
            OP_CROSS:
            begin
                ml[0] = in_a[1]; mr[0] = in_b[2];
                ml[1] = in_a[2]; mr[1] = in_b[1];
                ml[2] = in_a[2]; mr[2] = in_b[0];
                ml[3] = in_a[0]; mr[3] = in_b[2];
                ml[4] = in_a[0]; mr[4] = in_b[1];
                ml[5] = in_a[1]; mr[5] = in_b[0];
            end
            OP_DOT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    ml[k] = in_a[k];
                    mr[k] = in_b[k];
                end
            end
            OP_SCALE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    ml[k] = in_s;
                    mr[k] = in_a[k];
                end
            end
            OP_LENGTH, OP_NORMALIZE:
            begin
                // squares for the sum of squares
                for (int k = 0; k < 3; k++)
                begin
                    ml[k] = in_a[k];
                    mr[k] = in_a[k];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            prod_next[k] = $signed(ml[k]) * $signed(mr[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= in_op;
            a_reg    <= in_a;
            lin_reg  <= lin_next;
            prod_reg <= prod_next;
        end
    end

endmodule

@@ hdl/v3a_post_cell.sv @@
// v3a_post_cell: rounds and sums products, clips vector and dot results,
// forms the sum of squares and |a| for length/normalize. Depends on v3a_pkg.
`timescale 1ns / 1ps

module v3a_post_cell #(
    parameter int CW = v3a_pkg::COMPONENT_WIDTH_DEF,
    parameter int FB = v3a_pkg::FRACTION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  v3a_pkg::op_t                      in_op,
    input  logic [2:0][CW-1:0]                in_a,
    input  logic [2:0][CW:0]                  in_lin,
    input  logic [5:0][2*CW-1:0]              in_prod,
    output logic                              out_valid,
    input  logic                              out_ready,
    output v3a_pkg::op_t                      out_op,
    output logic [2:0][CW-1:0]                out_vec,
    output logic [v3a_pkg::SCALAR_WIDTH-1:0]  out_sc,
    output logic                              out_sat,
    output logic [2:0]                        out_neg,
    output logic [2:0][CW-1:0]                out_abs,
    output logic [2*CW-1:0]                   out_sumsq
);
    import v3a_pkg::*;

    localparam int WIDE = 2*CW + FB + SCALAR_WIDTH + 2;
    localparam int SQW  = 2*CW;
    localparam logic signed [WIDE-1:0] HALF = WIDE'(1) <<< (FB-1);
    localparam logic signed [WIDE-1:0] CMAX = (WIDE'(1) <<< (CW-1)) - WIDE'(1);
    localparam logic signed [WIDE-1:0] CMIN = -CMAX - WIDE'(1);
    localparam logic signed [WIDE-1:0] SMAX = (WIDE'(1) <<< (SCALAR_WIDTH-1)) - WIDE'(1);
    localparam logic signed [WIDE-1:0] SMIN = -SMAX - WIDE'(1);

    // round to nearest, ties up, then drop the fraction bits
    function automatic logic signed [WIDE-1:0] rnd(input logic signed [WIDE-1:0] v);
        return (v + HALF) >>> FB;
    endfunction

    function automatic logic [CW:0] clip_c(input logic signed [WIDE-1:0] v);
        if (v > CMAX)
            return {1'b1, CMAX[CW-1:0]};
        else if (v < CMIN)
            return {1'b1, CMIN[CW-1:0]};
        else
            return {1'b0, v[CW-1:0]};
    endfunction

    function automatic logic [SCALAR_WIDTH:0] clip_s(input logic signed [WIDE-1:0] v);
        if (v > SMAX)
            return {1'b1, SMAX[SCALAR_WIDTH-1:0]};
        else if (v < SMIN)
            return {1'b1, SMIN[SCALAR_WIDTH-1:0]};
        else
            return {1'b0, v[SCALAR_WIDTH-1:0]};
    endfunction

    logic                        valid_reg;
    op_t                         op_reg;
    logic [2:0][CW-1:0]          vec_reg;
    logic [2:0][CW-1:0]          vec_next;
    logic [SCALAR_WIDTH-1:0]     sc_reg;
    logic [SCALAR_WIDTH-1:0]     sc_next;
    logic                        sat_reg;
    logic                        sat_next;
    logic [2:0]                  neg_reg;
    logic [2:0]                  neg_next;
    logic [2:0][CW-1:0]          abs_reg;
    logic [2:0][CW-1:0]          abs_next;
    logic [SQW-1:0]              sumsq_reg;
    logic [SQW-1:0]              sumsq_next;
    logic signed [WIDE-1:0]      ext [6];
    logic signed [WIDE-1:0]      vraw [3];
    logic signed [WIDE-1:0]      sraw;
    logic [CW:0]                 vclip [3];
    logic [SCALAR_WIDTH:0]       sclip;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_op    = op_reg;
    assign out_vec   = vec_reg;
    assign out_sc    = sc_reg;
    assign out_sat   = sat_reg;
    assign out_neg   = neg_reg;
    assign out_abs   = abs_reg;
    assign out_sumsq = sumsq_reg;

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            ext[k] = WIDE'($signed(in_prod[k]));
        end
        for (int k = 0; k < 3; k++)
        begin
            vraw[k] = '0;
        end
        sraw = '0;
        unique case (in_op) inside
            OP_ADD, OP_SUB, OP_NEGATE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    vraw[k] = WIDE'($signed(in_lin[k]));
                end
            end
            OP_CROSS:
            begin
                vraw[0] = rnd(ext[0] - ext[1]);
                vraw[1] = rnd(ext[2] - ext[3]);
                vraw[2] = rnd(ext[4] - ext[5]);
            end
            OP_SCALE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    vraw[k] = rnd(ext[k]);
                end
            end
            OP_DOT:
            begin
                sraw = rnd(ext[0] + ext[1] + ext[2]);
            end
            default:
            begin
            end
        endcase

        sclip    = clip_s(sraw);
        sat_next = sclip[SCALAR_WIDTH];
        sc_next  = sclip[SCALAR_WIDTH-1:0];
        for (int k = 0; k < 3; k++)
        begin
            vclip[k]    = clip_c(vraw[k]);
            vec_next[k] = vclip[k][CW-1:0];
            sat_next    = sat_next | vclip[k][CW];
            neg_next[k] = in_a[k][CW-1];
            // most negative value maps to 2^(CW-1), still fits unsigned
            abs_next[k] = in_a[k][CW-1] ? (~in_a[k] + 1'b1) : in_a[k];
        end
        sumsq_next = in_prod[0] + in_prod[1] + in_prod[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= in_op;
            vec_reg   <= vec_next;
            sc_reg    <= sc_next;
            sat_reg   <= sat_next;
            neg_reg   <= neg_next;
            abs_reg   <= abs_next;
            sumsq_reg <= sumsq_next;
        end
    end

endmodule

@@ hdl/v3a_sqrt_cell.sv @@
// v3a_sqrt_cell: one root bit of the digit-by-digit integer square root.
// Chained CW times; carries an opaque sideband. Depends on v3a_pkg.
`timescale 1ns / 1ps

module v3a_sqrt_cell #(
    parameter int CW     = v3a_pkg::COMPONENT_WIDTH_DEF,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [SIDE_W-1:0] in_side,
    input  logic [2*CW-1:0]   in_rad,
    input  logic [CW:0]       in_rem,
    input  logic [CW-1:0]     in_root,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SIDE_W-1:0] out_side,
    output logic [2*CW-1:0]   out_rad,
    output logic [CW:0]       out_rem,
    output logic [CW-1:0]     out_root
);
    import v3a_pkg::*;

    logic              valid_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [2*CW-1:0]   rad_reg;
    logic [2*CW-1:0]   rad_next;
    logic [CW:0]       rem_reg;
    logic [CW:0]       rem_next;
    logic [CW-1:0]     root_reg;
    logic [CW-1:0]     root_next;
    logic [CW+2:0]     cur;
    logic [CW+2:0]     trial;
    logic [CW+2:0]     diff;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

    always_comb
    begin
        // bring down the next two radicand bits, try root*4+1
        cur      = {in_rem, in_rad[2*CW-1 -: 2]};
        trial    = {1'b0, in_root, 2'b01};
        diff     = cur - trial;
        rad_next = {in_rad[2*CW-3:0], 2'b00};
        if (cur >= trial)
        begin
            rem_next  = diff[CW:0];
            root_next = {in_root[CW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = cur[CW:0];
            root_next = {in_root[CW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            side_reg <= in_side;
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

endmodule

@@ hdl/v3a_div_cell.sv @@
// v3a_div_cell: one quotient bit of a restoring divide, three lanes sharing one divisor.
// Chained NW times; carries an opaque sideband. Depends on v3a_pkg.
`timescale 1ns / 1ps

module v3a_div_cell #(
    parameter int CW     = v3a_pkg::COMPONENT_WIDTH_DEF,
    parameter int NW     = v3a_pkg::COMPONENT_WIDTH_DEF + v3a_pkg::FRACTION_BITS_DEF,
    parameter int SIDE_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [SIDE_W-1:0]  in_side,
    input  logic [CW-1:0]      in_len,
    input  logic [2:0][CW-1:0] in_rem,
    input  logic [2:0][NW-1:0] in_nq,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SIDE_W-1:0]  out_side,
    output logic [CW-1:0]      out_len,
    output logic [2:0][CW-1:0] out_rem,
    output logic [2:0][NW-1:0] out_nq
);
    import v3a_pkg::*;

    logic               valid_reg;
    logic [SIDE_W-1:0]  side_reg;
    logic [CW-1:0]      len_reg;
    logic [2:0][CW-1:0] rem_reg;
    logic [2:0][CW-1:0] rem_next;
    logic [2:0][NW-1:0] nq_reg;
    logic [2:0][NW-1:0] nq_next;
    logic [CW:0]        cur [3];
    logic [CW:0]        diff [3];
    logic               qbit [3];

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_len   = len_reg;
    assign out_rem   = rem_reg;
    assign out_nq    = nq_reg;

    // numerator bits shift out the top of nq while quotient bits enter at the bottom
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cur[k]      = {in_rem[k], in_nq[k][NW-1]};
            diff[k]     = cur[k] - {1'b0, in_len};
            qbit[k]     = (cur[k] >= {1'b0, in_len});
            rem_next[k] = qbit[k] ? diff[k][CW-1:0] : cur[k][CW-1:0];
            nq_next[k]  = {in_nq[k][NW-2:0], qbit[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            side_reg <= in_side;
            len_reg  <= in_len;
            rem_reg  <= rem_next;
            nq_reg   <= nq_next;
        end
    end

endmodule

@@ hdl/vector3_alu.sv @@
// vector3_alu: pipelined 3-D fixed-point vector ALU, one result per transaction.
// Every op takes the same path: product cell, round/sum/clip cell, square-root cells
// (one root bit each), divider cells (one quotient bit each), output register. Each cell
// stalls only when its successor is full; otherwise one transaction per cycle flows through.
// Reset: rst_n asynchronous, active low, clears every valid flag; data registers are not reset.
`timescale 1ns / 1ps

module vector3_alu #(
    parameter int COMPONENT_WIDTH = v3a_pkg::COMPONENT_WIDTH_DEF,
    parameter int FRACTION_BITS   = v3a_pkg::FRACTION_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // operation, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor; zero pad on top
    input  logic [((v3a_pkg::OP_WIDTH+7*COMPONENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // result_x, result_y, result_z, result_scalar, saturated, zero_length; zero pad
    output logic [((3*COMPONENT_WIDTH+v3a_pkg::SCALAR_WIDTH+2+7)/8)*8-1:0] m_axis_tdata
);
    import v3a_pkg::*;

    localparam int CW    = COMPONENT_WIDTH;
    localparam int FB    = FRACTION_BITS;
    localparam int NW    = CW + FB;
    localparam int WIDE  = 2*CW + FB + SCALAR_WIDTH + 2;
    localparam int OUT_W = 3*CW + SCALAR_WIDTH + 2;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
    localparam logic signed [WIDE-1:0] CMAX = (WIDE'(1) <<< (CW-1)) - WIDE'(1);
    localparam logic signed [WIDE-1:0] CMIN = -CMAX - WIDE'(1);
    localparam logic signed [WIDE-1:0] SMAX = (WIDE'(1) <<< (SCALAR_WIDTH-1)) - WIDE'(1);

    typedef struct packed {
        op_t                     op;
        logic [2:0][CW-1:0]      vec;
        logic [SCALAR_WIDTH-1:0] sc;
        logic                    sat;
        logic [2:0]              neg;
    } side_t;

    typedef struct packed {
        logic [2:0][CW-1:0] abs_a;
        side_t              main;
    } sq_side_t;

    localparam int SIDE_W    = $bits(side_t);
    localparam int SQ_SIDE_W = $bits(sq_side_t);

    function automatic logic [CW:0] clip_c(input logic signed [WIDE-1:0] v);
        if (v > CMAX)
            return {1'b1, CMAX[CW-1:0]};
        else if (v < CMIN)
            return {1'b1, CMIN[CW-1:0]};
        else
            return {1'b0, v[CW-1:0]};
    endfunction

    // ---------------- input unpack ----------------
    op_t                in_op;
    logic [2:0][CW-1:0] in_a;
    logic [2:0][CW-1:0] in_b;
    logic [CW-1:0]      in_s;

    assign in_op = op_t'(s_axis_tdata[OP_WIDTH-1:0]);
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            in_a[k] = s_axis_tdata[OP_WIDTH + k*CW +: CW];
            in_b[k] = s_axis_tdata[OP_WIDTH + (3+k)*CW +: CW];
        end
        in_s = s_axis_tdata[OP_WIDTH + 6*CW +: CW];
    end

    // ---------------- products ----------------
    logic                 mul_valid;
    logic                 mul_ready;
    op_t                  mul_op;
    logic [2:0][CW-1:0]   mul_a;
    logic [2:0][CW:0]     mul_lin;
    logic [5:0][2*CW-1:0] mul_prod;

    v3a_mul_cell #(.CW(CW)) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (in_op),
        .in_a      (in_a),
        .in_b      (in_b),
        .in_s      (in_s),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_op    (mul_op),
        .out_a     (mul_a),
        .out_lin   (mul_lin),
        .out_prod  (mul_prod)
    );

    // ---------------- round / sum / clip ----------------
    logic                    post_valid;
    logic                    post_ready;
    op_t                     post_op;
    logic [2:0][CW-1:0]      post_vec;
    logic [SCALAR_WIDTH-1:0] post_sc;
    logic                    post_sat;
    logic [2:0]              post_neg;
    logic [2:0][CW-1:0]      post_abs;
    logic [2*CW-1:0]         post_sumsq;
    sq_side_t                post_side;

    v3a_post_cell #(.CW(CW), .FB(FB)) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .in_op     (mul_op),
        .in_a      (mul_a),
        .in_lin    (mul_lin),
        .in_prod   (mul_prod),
        .out_valid (post_valid),
        .out_ready (post_ready),
        .out_op    (post_op),
        .out_vec   (post_vec),
        .out_sc    (post_sc),
        .out_sat   (post_sat),
        .out_neg   (post_neg),
        .out_abs   (post_abs),
        .out_sumsq (post_sumsq)
    );

    always_comb
    begin
        post_side.abs_a    = post_abs;
        post_side.main.op  = post_op;
        post_side.main.vec = post_vec;
        post_side.main.sc  = post_sc;
        post_side.main.sat = post_sat;
        post_side.main.neg = post_neg;
    end

    // ---------------- square-root chain ----------------
    logic                 sq_valid [CW+1];
    logic                 sq_ready [CW+1];
    logic [SQ_SIDE_W-1:0] sq_side  [CW+1];
    logic [2*CW-1:0]      sq_rad   [CW+1];
    logic [CW:0]          sq_rem   [CW+1];
    logic [CW-1:0]        sq_root  [CW+1];

    assign sq_valid[0] = post_valid;
    assign post_ready  = sq_ready[0];
    assign sq_side[0]  = post_side;
    assign sq_rad[0]   = post_sumsq;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;

    for (genvar i = 0; i < CW; i++)
    begin : g_sqrt
        v3a_sqrt_cell #(.CW(CW), .SIDE_W(SQ_SIDE_W)) u_sqrt (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[i]),
            .in_ready  (sq_ready[i]),
            .in_side   (sq_side[i]),
            .in_rad    (sq_rad[i]),
            .in_rem    (sq_rem[i]),
            .in_root   (sq_root[i]),
            .out_valid (sq_valid[i+1]),
            .out_ready (sq_ready[i+1]),
            .out_side  (sq_side[i+1]),
            .out_rad   (sq_rad[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_root  (sq_root[i+1])
        );
    end

    sq_side_t sq_last;
    assign sq_last = sq_side_t'(sq_side[CW]);

    // ---------------- divider chain ----------------
    logic               dv_valid [NW+1];
    logic               dv_ready [NW+1];
    logic [SIDE_W-1:0]  dv_side  [NW+1];
    logic [CW-1:0]      dv_len   [NW+1];
    logic [2:0][CW-1:0] dv_rem   [NW+1];
    logic [2:0][NW-1:0] dv_nq    [NW+1];

    assign dv_valid[0]  = sq_valid[CW];
    assign sq_ready[CW] = dv_ready[0];
    assign dv_side[0]   = sq_last.main;
    assign dv_len[0]    = sq_root[CW];
    assign dv_rem[0]    = '0;
    assign dv_nq[0]     = {{sq_last.abs_a[2], {FB{1'b0}}},
                           {sq_last.abs_a[1], {FB{1'b0}}},
                           {sq_last.abs_a[0], {FB{1'b0}}}};

    for (genvar i = 0; i < NW; i++)
    begin : g_div
        v3a_div_cell #(.CW(CW), .NW(NW), .SIDE_W(SIDE_W)) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[i]),
            .in_ready  (dv_ready[i]),
            .in_side   (dv_side[i]),
            .in_len    (dv_len[i]),
            .in_rem    (dv_rem[i]),
            .in_nq     (dv_nq[i]),
            .out_valid (dv_valid[i+1]),
            .out_ready (dv_ready[i+1]),
            .out_side  (dv_side[i+1]),
            .out_len   (dv_len[i+1]),
            .out_rem   (dv_rem[i+1]),
            .out_nq    (dv_nq[i+1])
        );
    end

    // ---------------- result select and output register ----------------
    side_t                   fin;
    logic [CW-1:0]           fin_len;
    logic [NW:0]             qr   [3];
    logic signed [WIDE-1:0]  qe   [3];
    logic [CW:0]             qclip [3];
    logic signed [WIDE-1:0]  len_e;
    logic [2:0][CW-1:0]      vec_next;
    logic [SCALAR_WIDTH-1:0] sc_next;
    logic                    sat_next;
    logic                    zl_next;

    logic                    out_valid_reg;
    logic                    out_ready;
    logic [2:0][CW-1:0]      vec_reg;
    logic [SCALAR_WIDTH-1:0] sc_reg;
    logic                    sat_reg;
    logic                    zl_reg;

    assign fin     = side_t'(dv_side[NW]);
    assign fin_len = dv_len[NW];

    always_comb
    begin
        // quotient rounds up when twice the remainder reaches the divisor
        for (int k = 0; k < 3; k++)
        begin
            qr[k]    = {1'b0, dv_nq[NW][k]} +
                       (NW+1)'({dv_rem[NW][k], 1'b0} >= {1'b0, fin_len});
            qe[k]    = WIDE'(qr[k]);
            qe[k]    = fin.neg[k] ? -qe[k] : qe[k];
            qclip[k] = clip_c(qe[k]);
        end
        len_e    = WIDE'(fin_len);
        vec_next = fin.vec;
        sc_next  = fin.sc;
        sat_next = fin.sat;
        zl_next  = 1'b0;
        unique case (fin.op) inside
            OP_NORMALIZE:
            begin
                sc_next = '0;
                if (fin_len == '0)
                begin
                    vec_next = '0;
                    sat_next = 1'b0;
                    zl_next  = 1'b1;
                end
                else
                begin
                    sat_next = qclip[0][CW] | qclip[1][CW] | qclip[2][CW];
                    for (int k = 0; k < 3; k++)
                    begin
                        vec_next[k] = qclip[k][CW-1:0];
                    end
                end
            end
            OP_LENGTH:
            begin
                vec_next = '0;
                if (len_e > SMAX)
                begin
                    sc_next  = SMAX[SCALAR_WIDTH-1:0];
                    sat_next = 1'b1;
                end
                else
                begin
                    sc_next  = len_e[SCALAR_WIDTH-1:0];
                    sat_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_ready    = !out_valid_reg || m_axis_tready;
    assign dv_ready[NW] = out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= dv_valid[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_valid[NW] && out_ready)
        begin
            vec_reg <= vec_next;
            sc_reg  <= sc_next;
            sat_reg <= sat_next;
            zl_reg  <= zl_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TW'({zl_reg, sat_reg, sc_reg, vec_reg[2], vec_reg[1], vec_reg[0]});

`ifndef SYNTHESIS
    // a zero-length normalize always returns the zero vector
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && zl_reg) |-> (vec_reg == '0 && sc_reg == '0))
        else $error("zero_length with nonzero result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(zl_reg && sat_reg))
        else $error("zero_length and saturated both set");

    // with the output register empty every cell must be able to advance
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled while output register empty");
`endif

endmodule
